### sv/blps_pkg.sv
// Package: sizes, sequencer states and hash round codes for the probe set.
package blps_pkg;

  localparam int BUCKET_COUNT     = 256;
  localparam int SLOTS_PER_BUCKET = 256;

  localparam int BUCKET_BITS = $clog2(BUCKET_COUNT);
  localparam int SLOT_BITS   = $clog2(SLOTS_PER_BUCKET);
  localparam int ADDR_BITS   = BUCKET_BITS + SLOT_BITS;
  localparam int SLOT_DEPTH  = BUCKET_COUNT << SLOT_BITS;
  localparam int KEY_BITS    = 24;
  localparam int VALUE_BITS  = 32;
  localparam int FILL_BITS   = 8;
  localparam int HASH_BITS   = 64;
  localparam int MUL_BITS    = 32 + SLOT_BITS + 1;

  localparam logic [FILL_BITS-1:0] MAX_FILL_RESET = 8'd230;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ZERO,
    ST_HASH,
    ST_MUL,
    ST_READ,
    ST_CHECK
  } state_t;

  typedef enum logic [2:0] {
    RND_NOT_SHL21,
    RND_XOR_SHR24,
    RND_MUL9_SHL8,
    RND_XOR_SHR14,
    RND_MUL5_SHL4,
    RND_XOR_SHR28
  } round_t;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_t;

endpackage

### sv/bucketed_linear_probe_set.sv
// Top level: bucketed linear-probing set of 32-bit values with lookup and insert.
//
//   channel   direction  handshake             payload
//   -------   ---------  --------------------  -------------------------
//   command   in         start & !busy         operation, value
//   result    out        done (one cycle)      present, added, refused
//   config    in         cfg_write             cfg_data (max_fill)
//
// After reset the block sweeps the slot store, the fill counts and the zero-key
// flags to zero, one address per cycle, with busy high.
// A zero key is answered from the bucket flag. Any other key goes through an accept
// state, 6 hash rounds through the shared round unit and a multiply-high state,
// then a slot RAM read and a compare for each probed slot, probes 1..256.
// The result shows on done for one cycle as busy falls; the receiver cannot
// stall, so nothing waits on the output side.
module bucketed_linear_probe_set
  import blps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  operation,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  done,
  output logic                  present,
  output logic                  added,
  output logic                  refused,
  input  logic                  cfg_write,
  input  logic [FILL_BITS-1:0]  cfg_data
);

  // Sequencer state and item registers.
  state_t                 state, state_next;
  op_t                    op;
  logic [BUCKET_BITS-1:0] bucket;
  logic [KEY_BITS-1:0]    key;
  logic [HASH_BITS-1:0]   h;
  logic [HASH_BITS-1:0]   h_round;
  round_t                 round;
  logic [SLOT_BITS-1:0]   pos;
  logic [SLOT_BITS-1:0]   count;
  logic [ADDR_BITS-1:0]   clr_idx;
  logic [FILL_BITS-1:0]   max_fill;

  // RAM ports.
  logic                   slot_we;
  logic [ADDR_BITS-1:0]   slot_addr;
  logic [KEY_BITS-1:0]    slot_wdata, slot_rdata;
  logic                   fill_we;
  logic [BUCKET_BITS-1:0] fill_addr;
  logic [FILL_BITS-1:0]   fill_wdata, fill_rdata;
  logic                   zk_we;
  logic [BUCKET_BITS-1:0] zk_addr;
  logic [0:0]             zk_wdata, zk_rdata;

  // Decoded controls.
  logic accept;
  logic clr_last;
  logic last_round;
  logic last_probe;
  logic slot_empty, slot_hit;
  logic room;
  logic res_valid, res_present, res_added, res_refused;
  logic [MUL_BITS-1:0] product;

  assign accept     = start && !busy;
  assign clr_last   = (clr_idx == {ADDR_BITS{1'b1}});
  assign last_round = (round == RND_XOR_SHR28);
  assign last_probe = (count == SLOT_BITS'(SLOTS_PER_BUCKET - 1));
  assign slot_empty = (slot_rdata == '0);
  assign slot_hit   = (slot_rdata == key);
  assign room       = (fill_rdata < max_fill);
  // Multiply-high maps the 32-bit hash onto a home slot of the region.
  assign product    = MUL_BITS'(h[31:0]) * MUL_BITS'(SLOTS_PER_BUCKET);

  blps_hash u_hash (
    .round  (round),
    .h      (h),
    .h_next (h_round)
  );

  blps_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOT_DEPTH)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .addr  (slot_addr),
    .wdata (slot_wdata),
    .rdata (slot_rdata)
  );

  blps_ram #(.WIDTH(FILL_BITS), .DEPTH(BUCKET_COUNT)) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .addr  (fill_addr),
    .wdata (fill_wdata),
    .rdata (fill_rdata)
  );

  blps_ram #(.WIDTH(1), .DEPTH(BUCKET_COUNT)) u_zk_ram (
    .clk   (clk),
    .we    (zk_we),
    .addr  (zk_addr),
    .wdata (zk_wdata),
    .rdata (zk_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = (value[VALUE_BITS-1:BUCKET_BITS] == '0) ? ST_ZERO : ST_HASH;
        end
      end
      ST_ZERO:  state_next = ST_IDLE;
      ST_HASH: begin
        if (last_round) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:   state_next = ST_READ;
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: begin
        if (slot_empty || slot_hit || last_probe) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_READ;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs and RAM controls.
  always_comb begin
    busy        = (state != ST_IDLE);
    slot_we     = 1'b0;
    slot_addr   = {bucket, pos};
    slot_wdata  = key;
    fill_we     = 1'b0;
    fill_addr   = bucket;
    fill_wdata  = fill_rdata + FILL_BITS'(1);
    zk_we       = 1'b0;
    zk_addr     = bucket;
    zk_wdata    = 1'b1;
    res_valid   = 1'b0;
    res_present = 1'b0;
    res_added   = 1'b0;
    res_refused = 1'b0;
    case (state)
      ST_CLEAR: begin
        // Zero one slot per cycle; the bucket tables ride on the low bits.
        slot_we    = 1'b1;
        slot_addr  = clr_idx;
        slot_wdata = '0;
        fill_we    = 1'b1;
        fill_addr  = clr_idx[BUCKET_BITS-1:0];
        fill_wdata = '0;
        zk_we      = 1'b1;
        zk_addr    = clr_idx[BUCKET_BITS-1:0];
        zk_wdata   = 1'b0;
      end
      ST_IDLE: begin
        // Fetch the bucket's fill count and zero-key flag as the command lands.
        fill_addr = value[BUCKET_BITS-1:0];
        zk_addr   = value[BUCKET_BITS-1:0];
      end
      ST_ZERO: begin
        // Key zero lives in the bucket flag and never touches the fill count.
        res_valid   = 1'b1;
        res_present = zk_rdata[0];
        if (op == OP_INSERT) begin
          zk_we     = 1'b1;
          res_added = !zk_rdata[0];
        end
      end
      ST_CHECK: begin
        if (slot_hit && !slot_empty) begin
          res_valid   = 1'b1;
          res_present = 1'b1;
        end else if (slot_empty) begin
          res_valid = 1'b1;
          if (op == OP_INSERT) begin
            if (room) begin
              slot_we   = 1'b1;
              fill_we   = 1'b1;
              res_added = 1'b1;
            end else begin
              res_refused = 1'b1;
            end
          end
        end else if (last_probe) begin
          // Region full and key absent: refuse an insert.
          res_valid   = 1'b1;
          res_refused = (op == OP_INSERT);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_idx  <= '0;
      max_fill <= MAX_FILL_RESET;
      done     <= 1'b0;
      present  <= 1'b0;
      added    <= 1'b0;
      refused  <= 1'b0;
    end else begin
      state   <= state_next;
      done    <= res_valid;
      present <= res_valid && res_present;
      added   <= res_valid && res_added;
      refused <= res_valid && res_refused;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + ADDR_BITS'(1);
      end
      if (cfg_write) begin
        max_fill <= cfg_data;
      end
    end
  end

  // Item datapath: load on accept, advance the hash, then walk the probe.
  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= op_t'(operation);
      bucket <= value[BUCKET_BITS-1:0];
      key    <= value[VALUE_BITS-1:BUCKET_BITS];
      h      <= HASH_BITS'(value[VALUE_BITS-1:BUCKET_BITS]);
      round  <= RND_NOT_SHL21;
    end
    if (state == ST_HASH) begin
      h     <= h_round;
      round <= round_t'(round + 3'd1);
    end
    if (state == ST_MUL) begin
      pos   <= product[32 +: SLOT_BITS];
      count <= '0;
    end
    if (state == ST_CHECK) begin
      // Step to the next slot, wrapping inside the bucket region.
      pos   <= (pos == SLOT_BITS'(SLOTS_PER_BUCKET - 1)) ? '0 : pos + SLOT_BITS'(1);
      count <= count + SLOT_BITS'(1);
    end
  end

endmodule

### sv/blps_ram.sv
// Generic single-port RAM with registered read data.
module blps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### sv/blps_hash.sv
// Shared hash round unit: applies one shift-add or shift-xor round per use.
module blps_hash
  import blps_pkg::*;
(
  input  round_t               round,
  input  logic [HASH_BITS-1:0] h,
  output logic [HASH_BITS-1:0] h_next
);

  always_comb begin
    case (round)
      RND_NOT_SHL21: h_next = (~h) + (h << 21);
      RND_XOR_SHR24: h_next = h ^ (h >> 24);
      RND_MUL9_SHL8: h_next = h + (h << 3) + (h << 8);
      RND_XOR_SHR14: h_next = h ^ (h >> 14);
      RND_MUL5_SHL4: h_next = h + (h << 2) + (h << 4);
      RND_XOR_SHR28: h_next = h ^ (h >> 28);
      default:       h_next = h;
    endcase
  end

endmodule

### sv/blps_checker.sv
// Port-level checker for the probe set and its bind to the top level.
module blps_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic present,
  input logic added,
  input logic refused
);

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transfer did not raise busy");

  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    done |-> !(added && refused) && !(present && (added || refused)))
    else $error("conflicting result flags");

  a_quiet: assert property (@(posedge clk) disable iff (rst)
    !done |-> !present && !added && !refused)
    else $error("result flags without strobe");

endmodule

bind bucketed_linear_probe_set blps_checker u_blps_checker (.*);

### verif/bucketed_linear_probe_set_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bucketed linear-probing set: lookups, inserts, fill limits.
module bucketed_linear_probe_set_test
  import blps_pkg::*;
();

  // Longest legal quiet stretch is the clearing sweep after reset over every slot;
  // allow it several times over before calling the run hung.
  localparam int STALL_LIMIT   = 3 * SLOT_DEPTH;
  // Cycles to keep watching after the last result, so a stray strobe still gets caught.
  localparam int SETTLE_CYCLES = 16;
  localparam int POOL_DEPTH    = 512;

  // One expected reply, kept with the item that caused it for readable mismatch reports.
  typedef struct {
    logic [VALUE_BITS-1:0] value;
    op_t                   op;
    logic                  present;
    logic                  added;
    logic                  refused;
  } set_reply_t;

  // Block ports; every input holds a known value from time zero.
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  start     = 1'b0;
  logic                  busy;
  logic                  operation = 1'b0;
  logic [VALUE_BITS-1:0] value     = '0;
  logic                  done;
  logic                  present;
  logic                  added;
  logic                  refused;
  logic                  cfg_write = 1'b0;
  logic [FILL_BITS-1:0]  cfg_data  = '0;

  // Shadow copy of the set: slot regions, per-bucket fill counts and zero-key flags.
  logic [KEY_BITS-1:0]  shadow_slots    [SLOT_DEPTH];
  logic [FILL_BITS-1:0] shadow_fill     [BUCKET_COUNT];
  logic                 shadow_zero_key [BUCKET_COUNT];
  logic [FILL_BITS-1:0] shadow_max_fill;

  // Replies still owed by the block, oldest first.
  set_reply_t pending_replies [$];
  // Values known to be stored; reused so lookups and repeat inserts actually hit.
  logic [VALUE_BITS-1:0] value_pool [$];

  int idle_pct        = 36;
  int error_count     = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int hit_count       = 0;
  int added_count     = 0;
  int refused_count   = 0;
  int stall_cycles    = 0;

  bucketed_linear_probe_set u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .value     (value),
    .done      (done),
    .present   (present),
    .added     (added),
    .refused   (refused),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Integer hash of a 24-bit key, then multiply-high onto a home slot of the region.
  function automatic logic [SLOT_BITS-1:0] key_home_slot(logic [KEY_BITS-1:0] key);
    logic [63:0] h;
    logic [63:0] prod;
    h = {{(64-KEY_BITS){1'b0}}, key};
    h = ~h + (h << 21);
    h = h ^ (h >> 24);
    h = h + (h << 3) + (h << 8);
    h = h ^ (h >> 14);
    h = h + (h << 2) + (h << 4);
    h = h ^ (h >> 28);
    prod = {32'd0, h[31:0]} * 64'(SLOTS_PER_BUCKET);
    return prod[32 +: SLOT_BITS];
  endfunction

  // Work out the reply to one accepted item and advance the shadow set.
  function automatic set_reply_t predict_membership(op_t op, logic [VALUE_BITS-1:0] v);
    set_reply_t          r;
    logic [BUCKET_BITS-1:0] bucket;
    logic [KEY_BITS-1:0]    key;
    logic [KEY_BITS-1:0]    entry;
    logic [SLOT_BITS-1:0]   pos;
    logic                   found;
    logic                   empty;
    r.value   = v;
    r.op      = op;
    r.present = 1'b0;
    r.added   = 1'b0;
    r.refused = 1'b0;
    bucket = v[BUCKET_BITS-1:0];
    key    = v[BUCKET_BITS +: KEY_BITS];
    if (key == '0) begin
      // Zero means an empty slot, so the zero key lives in the bucket's flag.
      r.present = shadow_zero_key[bucket];
      if (op == OP_INSERT) begin
        r.added = !r.present;
        shadow_zero_key[bucket] = 1'b1;
      end
    end else begin
      found = 1'b0;
      empty = 1'b0;
      pos   = key_home_slot(key);
      // Walk forward with wrap until the key, an empty slot, or a full lap.
      for (int n = 0; n < SLOTS_PER_BUCKET && !found && !empty; n++) begin
        entry = shadow_slots[{bucket, pos}];
        if (entry == '0)
          empty = 1'b1;
        else if (entry == key)
          found = 1'b1;
        else
          pos = pos + SLOT_BITS'(1);
      end
      r.present = found;
      if (op == OP_INSERT && !found) begin
        if (empty && shadow_fill[bucket] < shadow_max_fill) begin
          shadow_slots[{bucket, pos}] = key;
          shadow_fill[bucket] = shadow_fill[bucket] + FILL_BITS'(1);
          r.added = 1'b1;
        end else begin
          r.refused = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Present one item, hold it until the block takes it, then maybe idle for a while.
  task automatic send_item(op_t op, logic [VALUE_BITS-1:0] v);
    set_reply_t r;
    @(negedge clk);
    start     <= 1'b1;
    operation <= op;
    value     <= v;
    // The transfer happens at the first rising edge with busy low.
    do @(posedge clk); while (busy !== 1'b0);
    r = predict_membership(op, v);
    pending_replies.push_back(r);
    items_sent++;
    if (r.present) hit_count++;
    if (r.refused) refused_count++;
    if (r.added) begin
      added_count++;
      value_pool.push_back(v);
      if (value_pool.size() > POOL_DEPTH) void'(value_pool.pop_front());
    end
    // Start stays high when the next item follows at once; drop it only for a gap.
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
  endtask

  // Drop start and hold off until every owed reply has come back.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
  endtask

  // Write max_fill only with the block idle; track it in the shadow copy.
  task automatic set_max_fill(logic [FILL_BITS-1:0] limit);
    drain_results();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= limit;
    @(negedge clk);
    cfg_write <= 1'b0;
    shadow_max_fill = limit;
  endtask

  // Random value biased toward a few busy buckets, stored values and the odd keys.
  function automatic logic [VALUE_BITS-1:0] pick_value();
    logic [BUCKET_BITS-1:0] bucket;
    logic [KEY_BITS-1:0]    key;
    int                     roll;
    roll = $urandom_range(99);
    if (roll < 35 && value_pool.size() != 0)
      return value_pool[$urandom_range(value_pool.size() - 1)];
    if ($urandom_range(99) < 75) begin
      case ($urandom_range(3))
        0:       bucket = 8'h00;
        1:       bucket = 8'hFF;
        2:       bucket = 8'h5C;
        default: bucket = 8'h5D;
      endcase
    end else begin
      bucket = BUCKET_BITS'($urandom);
    end
    roll = $urandom_range(99);
    if (roll < 10)
      key = '0;
    else if (roll < 15)
      key = '1;
    else
      key = KEY_BITS'($urandom);
    return {key, bucket};
  endfunction

  // Compare one reply field; report time, expected and actual on a miss.
  task automatic compare_field(string field, set_reply_t want, logic expected, logic actual);
    if (actual !== expected) begin
      $display("%0t: %s mismatch for op %0d value %h: expected %0b, actual %0b",
               $time, field, want.op, want.value, expected, actual);
      error_count++;
    end
  endtask

  // Check each strobed result against the oldest owed reply.
  always @(posedge clk) begin : check_results
    set_reply_t want;
    if (!rst && done === 1'b1) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: result with no pending item: expected none, actual %0b%0b%0b",
                 $time, present, added, refused);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        results_checked++;
        compare_field("present", want, want.present, present);
        compare_field("added", want, want.added, added);
        compare_field("refused", want, want.refused, refused);
      end
    end
  end

  // Count cycles in which nothing transfers on either side.
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || done === 1'b1)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("%0t: no transfer for %0d cycles, %0d replies owed",
             $time, stall_cycles, pending_replies.size());
    $display("CHECK FAILED");
    $finish;
  end

  // Lookup and insert at the field extremes, the zero key and repeat inserts,
  // all under the reset fill limit.
  task automatic test_basic_ops();
    send_item(OP_LOOKUP, 32'h0000_0000);   // zero key, nothing stored yet
    send_item(OP_INSERT, 32'h0000_0000);   // zero key goes to the flag
    send_item(OP_INSERT, 32'h0000_0000);   // already there
    send_item(OP_LOOKUP, 32'h0000_0000);
    send_item(OP_LOOKUP, 32'h0000_00FF);   // zero flag is per bucket
    send_item(OP_LOOKUP, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'hFFFF_FFFF);   // top key, top bucket
    send_item(OP_INSERT, 32'hFFFF_FFFF);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'hFFFF_FF00);   // top key, bottom bucket
    send_item(OP_LOOKUP, 32'hFFFF_FF01);   // same key, other bucket
    send_item(OP_INSERT, 32'h0000_0100);   // smallest non-zero key
    send_item(OP_INSERT, 32'h8000_0080);
    send_item(OP_LOOKUP, 32'h7FFF_FF7F);
    send_item(OP_LOOKUP, 32'h0000_0100);
  endtask

  // Refusal at the fill limit, a limit of zero and a limit of one.
  task automatic test_fill_limits();
    set_max_fill(8'd3);
    for (int i = 1; i <= 4; i++)
      send_item(OP_INSERT, {KEY_BITS'(i * 40503 + 7), 8'h42});   // last one is refused
    send_item(OP_INSERT, {KEY_BITS'(40510), 8'h42});            // present, not refused
    send_item(OP_INSERT, {KEY_BITS'(0), 8'h42});                // zero key never refused
    send_item(OP_LOOKUP, {KEY_BITS'(4 * 40503 + 7), 8'h42});    // refused key is absent
    set_max_fill(8'd0);
    send_item(OP_INSERT, {24'h5A5A5A, 8'h43});
    send_item(OP_INSERT, {KEY_BITS'(0), 8'h43});
    send_item(OP_LOOKUP, {24'h5A5A5A, 8'h43});
    set_max_fill(8'd1);
    send_item(OP_INSERT, {24'h123456, 8'h44});
    send_item(OP_INSERT, {24'h654321, 8'h44});
  endtask

  // Fill one bucket to the top limit so probes run long and wrap the region.
  task automatic test_crowded_bucket();
    set_max_fill(8'hFF);
    for (int i = 0; i < 260; i++) begin
      send_item(OP_INSERT, {KEY_BITS'($urandom_range(1, 24'hFF_FFFF)), 8'h99});
      if (i % 8 == 0)
        send_item(OP_LOOKUP, {KEY_BITS'($urandom), 8'h99});
    end
  endtask

  // Mixed random traffic under one idle rate and one fill limit.
  task automatic test_random_traffic(int pct, logic [FILL_BITS-1:0] limit, int count);
    op_t op;
    idle_pct = pct;
    set_max_fill(limit);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 55)
        op = OP_INSERT;
      else
        op = OP_LOOKUP;
      send_item(op, pick_value());
    end
  endtask

  initial begin
    // Shadow set starts the way the clearing sweep leaves the block.
    for (int i = 0; i < SLOT_DEPTH; i++) shadow_slots[i] = '0;
    for (int i = 0; i < BUCKET_COUNT; i++) begin
      shadow_fill[i]     = '0;
      shadow_zero_key[i] = 1'b0;
    end
    shadow_max_fill = MAX_FILL_RESET;

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // The first item simply waits out the clearing sweep behind busy.
    test_basic_ops();
    test_fill_limits();
    test_crowded_bucket();
    test_random_traffic(36, 8'd17, 200);
    test_random_traffic(68, 8'd120, 200);
    test_random_traffic(0, MAX_FILL_RESET, 200);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_replies.size() != 0) begin
      $display("%0t: replies never came: expected 0 owed, actual %0d",
               $time, pending_replies.size());
      error_count++;
    end

    $display("Sent %0d lookups and inserts, checked %0d replies:", items_sent, results_checked);
    $display("%0d present, %0d added, %0d refused; fill limits 230, 3, 0, 1, 255, 17, 120, 230.",
             hit_count, added_count, refused_count);
    $display("Sender idle 36, 68 and 0 percent.");
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
